@@ sv/sit_pkg.sv @@
`default_nettype none
package sit_pkg;

	// Internal numbers are signed Q32.32 held in 64 bits.
	typedef logic signed [63:0] q_t;

	localparam q_t Q_MAX = 64'sh7fff_ffff_ffff_ffff;
	localparam q_t Q_MIN = 64'sh8000_0000_0000_0000;
	localparam q_t Q_ONE = 64'sh0000_0001_0000_0000;
	localparam q_t Q_ZERO = 64'sh0;

	localparam logic [15:0] TOL_RESET = 16'd1;

	// Quotient bits made by the divider, one per stage.
	localparam int DIV_STEPS = 63;
	// Divider: set-up stage, one stage per quotient bit, sign stage.
	localparam int DIV_LAT = DIV_STEPS + 2;
	// Multiplier: magnitudes, partial products, sum and saturation.
	localparam int MUL_LAT = 3;
	// Line former: set-up, divider, slope, multiplier, offset.
	localparam int LINE_LAT = DIV_LAT + MUL_LAT + 3;
	// Whole pipeline: input, line former, compare, divider, multiplier, y, result.
	localparam int NSTG = LINE_LAT + DIV_LAT + MUL_LAT + 4;

	// Raw endpoints of one segment pair.
	typedef struct packed {
		logic [31:0] seg_a_start_x;
		logic [31:0] seg_a_start_y;
		logic [31:0] seg_a_end_x;
		logic [31:0] seg_a_end_y;
		logic [31:0] seg_b_start_x;
		logic [31:0] seg_b_start_y;
		logic [31:0] seg_b_end_x;
		logic [31:0] seg_b_end_y;
	} pts_t;

	// Decisions taken once both lines are known.
	typedef struct packed {
		logic par;
		logic same;
		logic ovl;
		logic dz;
	} xflag_t;

	function automatic q_t sadd(q_t x, q_t y);
		logic signed [64:0] s;
		s = {x[63], x} + {y[63], y};
		if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
		return q_t'(s[63:0]);
	endfunction

	function automatic q_t sneg(q_t x);
		return (x == Q_MIN) ? Q_MAX : -x;
	endfunction

	function automatic q_t ssub(q_t x, q_t y);
		return sadd(x, sneg(y));
	endfunction

	function automatic logic [63:0] mag(q_t v);
		logic [63:0] u;
		u = unsigned'(v);
		return v[63] ? (64'd0 - u) : u;
	endfunction

	// Magnitude clamped to the signed range of the given sign.
	function automatic q_t sat_mag(logic [63:0] m, logic neg);
		if (neg) begin
			if (m[63]) return Q_MIN;
			return -q_t'(m);
		end
		if (m[63]) return Q_MAX;
		return q_t'(m);
	endfunction

	function automatic logic below(q_t v, q_t t);
		logic [63:0] m;
		m = mag((v == Q_MIN) ? Q_MAX : v);
		return m < unsigned'(t);
	endfunction

	function automatic q_t widen(logic [31:0] v);
		return q_t'({{16{v[31]}}, v, 16'h0});
	endfunction

	function automatic q_t tolq(logic [15:0] tol);
		return q_t'({32'h0, tol, 16'h0});
	endfunction

	// Point (vx, vy) inside the box of P and Q widened by t.
	function automatic logic inbox(q_t vx, q_t vy, q_t px, q_t py, q_t qx, q_t qy, q_t t);
		q_t mxx;
		q_t mnx;
		q_t mxy;
		q_t mny;
		mxx = (px > qx) ? px : qx;
		mnx = (px > qx) ? qx : px;
		mxy = (py > qy) ? py : qy;
		mny = (py > qy) ? qy : py;
		return (vx < sadd(mxx, t)) && (sadd(vx, t) > mnx) &&
			(vy < sadd(mxy, t)) && (sadd(vy, t) > mny);
	endfunction

endpackage
`default_nettype wire

@@ sv/sit_in_if.sv @@
`default_nettype none
interface sit_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] seg_a_start_x;
	logic signed [31:0] seg_a_start_y;
	logic signed [31:0] seg_a_end_x;
	logic signed [31:0] seg_a_end_y;
	logic signed [31:0] seg_b_start_x;
	logic signed [31:0] seg_b_start_y;
	logic signed [31:0] seg_b_end_x;
	logic signed [31:0] seg_b_end_y;

	modport source (
		output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
		output seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
		input ready
	);
	modport sink (
		input valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
		input seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
		output ready
	);
endinterface
`default_nettype wire

@@ sv/sit_out_if.sv @@
`default_nettype none
interface sit_out_if;
	logic valid;
	logic ready;
	logic touches;

	modport source (output valid, touches, input ready);
	modport sink (input valid, touches, output ready);
endinterface
`default_nettype wire

@@ sv/sit_delay.sv @@
`default_nettype none
module sit_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	logic [W-1:0] sr_s [D];

	// Shift line that moves only when the pipeline advances.
	always_ff @(posedge clk) begin
		if (en) begin
			sr_s[0] <= d;
			for (int i = 1; i < D; i++) sr_s[i] <= sr_s[i-1];
		end
	end

	assign q = sr_s[D-1];

endmodule
`default_nettype wire

@@ sv/sit_mul.sv @@
`default_nettype none
module sit_mul import sit_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  wire q_t   a,
	input  wire q_t   b,
	output q_t        p
);

	logic [63:0] ua_s1, ub_s1;
	logic        neg_s1;
	logic [63:0] p00_s2, p01_s2, p10_s2, p11_s2;
	logic        neg_s2;
	logic [33:0] mid;
	logic [65:0] hi;
	q_t          p_s3;

	// Magnitudes and sign of the product.
	always_ff @(posedge clk) begin
		if (en) begin
			ua_s1  <= mag(a);
			ub_s1  <= mag(b);
			neg_s1 <= a[63] ^ b[63];
		end
	end

	// Four 32 by 32 partial products.
	always_ff @(posedge clk) begin
		if (en) begin
			p00_s2 <= 64'(ua_s1[31:0]) * 64'(ub_s1[31:0]);
			p01_s2 <= 64'(ua_s1[31:0]) * 64'(ub_s1[63:32]);
			p10_s2 <= 64'(ua_s1[63:32]) * 64'(ub_s1[31:0]);
			p11_s2 <= 64'(ua_s1[63:32]) * 64'(ub_s1[63:32]);
			neg_s2 <= neg_s1;
		end
	end

	// Sum the middle of the 128-bit product and clamp it.
	always_comb begin
		mid = 34'(p00_s2[63:32]) + 34'(p01_s2[31:0]) + 34'(p10_s2[31:0]);
		hi  = 66'(p11_s2) + 66'(p01_s2[63:32]) + 66'(p10_s2[63:32]) + 66'(mid[33:32]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (|hi[65:32]) p_s3 <= sat_mag(64'hffff_ffff_ffff_ffff, neg_s2);
			else p_s3 <= sat_mag({hi[31:0], mid[31:0]}, neg_s2);
		end
	end

	assign p = p_s3;

endmodule
`default_nettype wire

@@ sv/sit_div.sv @@
`default_nettype none
module sit_div import sit_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  wire q_t   n,
	input  wire q_t   d,
	output q_t        q
);

	logic [63:0] rem_s [DIV_STEPS+1];
	logic [62:0] dvd_s [DIV_STEPS+1];
	logic [62:0] quo_s [DIV_STEPS+1];
	logic [63:0] dsr_s [DIV_STEPS+1];
	logic        neg_s [DIV_STEPS+1];
	logic        ovf_s [DIV_STEPS+1];
	logic [63:0] un, ud;
	q_t          res;
	q_t          res_sout;

	// Set-up: magnitudes, and the overflow test |n| >= |d| * 2^31.
	always_comb begin
		un = mag(n);
		ud = mag(d);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= 64'(un[63:31]);
			dvd_s[0] <= {un[30:0], 32'h0};
			quo_s[0] <= '0;
			dsr_s[0] <= ud;
			neg_s[0] <= n[63] ^ d[63];
			ovf_s[0] <= {31'h0, un} >= {ud, 31'h0};
		end
	end

	// Restoring long division, one quotient bit per stage.
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic [64:0] rs;
		logic [64:0] df;

		always_comb begin
			rs = {rem_s[i], dvd_s[i][62]};
			df = rs - {1'b0, dsr_s[i]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= df[64] ? rs[63:0] : df[63:0];
				quo_s[i+1] <= {quo_s[i][61:0], ~df[64]};
				dvd_s[i+1] <= {dvd_s[i][61:0], 1'b0};
				dsr_s[i+1] <= dsr_s[i];
				neg_s[i+1] <= neg_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
		end
	end

	// Apply the sign, or clamp on overflow.
	always_comb begin
		if (ovf_s[DIV_STEPS]) res = neg_s[DIV_STEPS] ? Q_MIN : Q_MAX;
		else if (neg_s[DIV_STEPS]) res = -q_t'({1'b0, quo_s[DIV_STEPS]});
		else res = q_t'({1'b0, quo_s[DIV_STEPS]});
	end

	always_ff @(posedge clk) begin
		if (en) res_sout <= res;
	end

	assign q = res_sout;

endmodule
`default_nettype wire

@@ sv/sit_line.sv @@
`default_nettype none
module sit_line import sit_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  wire q_t   tq,
	input  wire q_t   px,
	input  wire q_t   py,
	input  wire q_t   qx,
	input  wire q_t   qy,
	output q_t        a,
	output logic      nv,
	output q_t        c
);

	q_t   dx;
	logic vert_s1;
	q_t   num_s1, den_s1, px_s1, py_s1;
	q_t   quo;
	logic vert_d1;
	q_t   px_d1, py_d1;
	q_t   a_s2, px_s2, py_s2;
	logic vert_s2;
	q_t   prod;
	q_t   a_d2, px_d2, py_d2;
	logic vert_d2;
	q_t   a_s3, c_s3;
	logic nv_s3;

	// Set-up: x extent decides a vertical line; y extent feeds the slope.
	assign dx = ssub(px, qx);

	always_ff @(posedge clk) begin
		if (en) begin
			vert_s1 <= below(dx, tq) || (dx == Q_ZERO);
			num_s1  <= ssub(py, qy);
			den_s1  <= dx;
			px_s1   <= px;
			py_s1   <= py;
		end
	end

	sit_div u_div (.clk, .en, .n(num_s1), .d(den_s1), .q(quo));

	sit_delay #(.W(129), .D(DIV_LAT)) u_dl1 (
		.clk, .en, .d({vert_s1, px_s1, py_s1}), .q({vert_d1, px_d1, py_d1})
	);

	// Slope term a.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s2    <= vert_d1 ? Q_ONE : sneg(quo);
			vert_s2 <= vert_d1;
			px_s2   <= px_d1;
			py_s2   <= py_d1;
		end
	end

	sit_mul u_mul (.clk, .en, .a(a_s2), .b(px_s2), .p(prod));

	sit_delay #(.W(193), .D(MUL_LAT)) u_dl2 (
		.clk, .en, .d({vert_s2, a_s2, px_s2, py_s2}), .q({vert_d2, a_d2, px_d2, py_d2})
	);

	// Offset term c.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s3  <= a_d2;
			nv_s3 <= ~vert_d2;
			c_s3  <= vert_d2 ? sneg(px_d2) : ssub(sneg(prod), py_d2);
		end
	end

	assign a  = a_s3;
	assign nv = nv_s3;
	assign c  = c_s3;

endmodule
`default_nettype wire

@@ sv/segment_intersection_test.sv @@
`default_nettype none
// Channel     Dir  Payload                                  Transfer when
// pairs_in    in   seg_a_start_x .. seg_b_end_y, 32b each   valid & ready
// result_out  out  touches, 1b                              valid & ready
//
// cfg         in   cfg_wdata, 16b tolerance                 cfg_we
//
// One segment pair per cycle while results are taken, over 143 register stages; most of the
// depth lies in the two 63-step divider pipelines (slopes, then crossing x) in series.
// Reset clears the valid bits and sets the tolerance to 1.
// The pipeline holds while the result register is full and not taken; the input stage
// still fills when it is empty.
module segment_intersection_test import sit_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  [15:0] cfg_wdata,
	sit_in_if.sink     pairs_in,
	sit_out_if.source  result_out
);

	logic [15:0]     tol_q;
	q_t              tq;
	logic [NSTG-1:0] vld_s;
	logic            en, en1;
	pts_t            in_s1;
	pts_t            pts_l, pts_x;
	q_t              a1, c1, a2, c2;
	logic            nv1, nv2;
	q_t              ax, ay, bx, by, cx, cy, dx, dy;
	q_t              b1, b2, den, num;
	logic            ysel;
	xflag_t          fl_s2, fl_d, fl_s3;
	q_t              den_s2, num_s2, am_s2, cm_s2;
	q_t              am_d, cm_d, x_div, x_d, prod;
	q_t              x_s3, y_s3;
	logic            touches_s4;

	// Tolerance register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tol_q <= TOL_RESET;
		else if (cfg_we) tol_q <= cfg_wdata;
	end

	assign tq = tolq(tol_q);

	// Global advance; the first stage may also fill a bubble.
	assign en  = ~vld_s[NSTG-1] | result_out.ready;
	assign en1 = en | ~vld_s[0];
	assign pairs_in.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en1) vld_s[0] <= pairs_in.valid;
			if (en) vld_s[NSTG-1:1] <= vld_s[NSTG-2:0];
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (en1) begin
			in_s1.seg_a_start_x <= pairs_in.seg_a_start_x;
			in_s1.seg_a_start_y <= pairs_in.seg_a_start_y;
			in_s1.seg_a_end_x   <= pairs_in.seg_a_end_x;
			in_s1.seg_a_end_y   <= pairs_in.seg_a_end_y;
			in_s1.seg_b_start_x <= pairs_in.seg_b_start_x;
			in_s1.seg_b_start_y <= pairs_in.seg_b_start_y;
			in_s1.seg_b_end_x   <= pairs_in.seg_b_end_x;
			in_s1.seg_b_end_y   <= pairs_in.seg_b_end_y;
		end
	end

	// Line equations of both segments.
	sit_line u_line_a (
		.clk, .en, .tq,
		.px(widen(in_s1.seg_a_start_x)), .py(widen(in_s1.seg_a_start_y)),
		.qx(widen(in_s1.seg_a_end_x)), .qy(widen(in_s1.seg_a_end_y)),
		.a(a1), .nv(nv1), .c(c1)
	);

	sit_line u_line_b (
		.clk, .en, .tq,
		.px(widen(in_s1.seg_b_start_x)), .py(widen(in_s1.seg_b_start_y)),
		.qx(widen(in_s1.seg_b_end_x)), .qy(widen(in_s1.seg_b_end_y)),
		.a(a2), .nv(nv2), .c(c2)
	);

	sit_delay #(.W($bits(pts_t)), .D(LINE_LAT)) u_pts_dl1 (
		.clk, .en, .d(in_s1), .q(pts_l)
	);

	// Parallel and overlap tests, and the crossing fraction.
	always_comb begin
		ax = widen(pts_l.seg_a_start_x);
		ay = widen(pts_l.seg_a_start_y);
		bx = widen(pts_l.seg_a_end_x);
		by = widen(pts_l.seg_a_end_y);
		cx = widen(pts_l.seg_b_start_x);
		cy = widen(pts_l.seg_b_start_y);
		dx = widen(pts_l.seg_b_end_x);
		dy = widen(pts_l.seg_b_end_y);
		b1 = nv1 ? Q_ONE : Q_ZERO;
		b2 = nv2 ? Q_ONE : Q_ZERO;
		// A product with b is either the other term or zero.
		den = ssub(nv2 ? a1 : Q_ZERO, nv1 ? a2 : Q_ZERO);
		num = ssub(nv1 ? c2 : Q_ZERO, nv2 ? c1 : Q_ZERO);
		ysel = below(b1, tq);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s2.par  <= below(ssub(a1, a2), tq) && below(ssub(b1, b2), tq);
			fl_s2.same <= below(ssub(c1, c2), tq);
			fl_s2.ovl  <= inbox(ax, ay, cx, cy, dx, dy, tq) || inbox(bx, by, cx, cy, dx, dy, tq) ||
				inbox(cx, cy, ax, ay, bx, by, tq) || inbox(dx, dy, ax, ay, bx, by, tq);
			fl_s2.dz   <= (den == Q_ZERO);
			den_s2     <= den;
			num_s2     <= num;
			am_s2      <= ysel ? a2 : a1;
			cm_s2      <= ysel ? c2 : c1;
		end
	end

	// Crossing x, then y from the chosen line.
	sit_div u_div (.clk, .en, .n(num_s2), .d(den_s2), .q(x_div));

	sit_delay #(.W(64), .D(DIV_LAT)) u_am_dl (.clk, .en, .d(am_s2), .q(am_d));

	sit_delay #(.W($bits(xflag_t) + 64), .D(DIV_LAT + MUL_LAT)) u_fl_dl (
		.clk, .en,
		.d({fl_s2, cm_s2}),
		.q({fl_d, cm_d})
	);

	sit_mul u_mul (.clk, .en, .a(am_d), .b(x_div), .p(prod));

	sit_delay #(.W(64), .D(MUL_LAT)) u_x_dl (.clk, .en, .d(x_div), .q(x_d));

	sit_delay #(.W($bits(pts_t)), .D(DIV_LAT + MUL_LAT + 2)) u_pts_dl2 (
		.clk, .en, .d(pts_l), .q(pts_x)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			y_s3  <= ssub(sneg(prod), cm_d);
			x_s3  <= x_d;
			fl_s3 <= fl_d;
		end
	end

	// Final decision into the result register.
	always_ff @(posedge clk) begin
		if (en) begin
			if (fl_s3.par) begin
				touches_s4 <= fl_s3.same && fl_s3.ovl;
			end else begin
				touches_s4 <= !fl_s3.dz &&
					inbox(x_s3, y_s3, widen(pts_x.seg_a_start_x), widen(pts_x.seg_a_start_y),
						widen(pts_x.seg_a_end_x), widen(pts_x.seg_a_end_y), tq) &&
					inbox(x_s3, y_s3, widen(pts_x.seg_b_start_x), widen(pts_x.seg_b_start_y),
						widen(pts_x.seg_b_end_x), widen(pts_x.seg_b_end_y), tq);
			end
		end
	end

	assign result_out.valid   = vld_s[NSTG-1];
	assign result_out.touches = touches_s4;

endmodule
`default_nettype wire

@@ sim/segment_intersection_test_tb.sv @@
`timescale 1ns / 100ps
module segment_intersection_test_tb;
	import sit_pkg::*;

	typedef logic signed [63:0] fx_t;
	typedef struct {
		fx_t a;
		fx_t b;
		fx_t c;
	} line_t;

	localparam fx_t FX_ONE = 64'sh0000_0001_0000_0000;
	localparam fx_t FX_TOP = 64'sh7fff_ffff_ffff_ffff;
	localparam fx_t FX_BOT = 64'sh8000_0000_0000_0000;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 200;
	localparam int LONG_HOLD = 600;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;

	sit_in_if pairs_in ();
	sit_out_if result_out ();

	segment_intersection_test dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.pairs_in(pairs_in),
		.result_out(result_out)
	);

	pts_t pending_pairs[$];
	logic expected_touch[$];
	logic [15:0] tol_now;
	int errors;
	int pairs_sent;
	int results_seen;
	int touch_count;
	int cycles;
	bit burst_mode;
	bit long_hold_req;
	pts_t cur_pair;
	int send_gap;
	int hold_left;

	// The clock toggles every half period.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Saturating Q32.32 arithmetic for the predictor.
	function automatic fx_t clamp_mag(logic [127:0] m, bit neg);
		logic [127:0] lim;
		lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 1);
		if (m > lim)
			m = lim;
		return neg ? -fx_t'(m[63:0]) : fx_t'(m[63:0]);
	endfunction

	function automatic logic [127:0] abs_wide(fx_t v);
		logic [63:0] u;
		u = v;
		return {64'd0, v[63] ? 64'd0 - u : u};
	endfunction

	function automatic fx_t fx_add(fx_t x, fx_t y);
		logic signed [64:0] s;
		s = 65'(x) + 65'(y);
		if (s > 65'(FX_TOP))
			return FX_TOP;
		if (s < 65'(FX_BOT))
			return FX_BOT;
		return s[63:0];
	endfunction

	function automatic fx_t fx_neg(fx_t x);
		return (x == FX_BOT) ? FX_TOP : -x;
	endfunction

	function automatic fx_t fx_sub(fx_t x, fx_t y);
		return fx_add(x, fx_neg(y));
	endfunction

	function automatic fx_t fx_mul(fx_t x, fx_t y);
		logic [127:0] p;
		p = (abs_wide(x) * abs_wide(y)) >> 32;
		return clamp_mag(p, x[63] != y[63]);
	endfunction

	function automatic fx_t fx_div(fx_t n, fx_t d);
		logic [127:0] q;
		q = (abs_wide(n) << 32) / abs_wide(d);
		return clamp_mag(q, n[63] != d[63]);
	endfunction

	function automatic bit within_tol(fx_t v, fx_t t);
		logic [127:0] m;
		m = abs_wide((v == FX_BOT) ? FX_TOP : v);
		return m < abs_wide(t);
	endfunction

	function automatic fx_t to_fx(logic [31:0] v);
		return {{16{v[31]}}, v, 16'h0};
	endfunction

	function automatic line_t line_through(fx_t px, fx_t py, fx_t qx, fx_t qy, fx_t t);
		line_t l;
		fx_t run;
		run = fx_sub(px, qx);
		if (within_tol(run, t) || run == 0) begin
			l.a = FX_ONE;
			l.b = 0;
			l.c = fx_neg(px);
		end else begin
			l.a = fx_neg(fx_div(fx_sub(py, qy), run));
			l.b = FX_ONE;
			l.c = fx_sub(fx_neg(fx_mul(l.a, px)), py);
		end
		return l;
	endfunction

	function automatic bit in_span(fx_t vx, fx_t vy, fx_t px, fx_t py, fx_t qx, fx_t qy,
			fx_t t);
		fx_t hx;
		fx_t lx;
		fx_t hy;
		fx_t ly;
		hx = (px > qx) ? px : qx;
		lx = (px > qx) ? qx : px;
		hy = (py > qy) ? py : qy;
		ly = (py > qy) ? qy : py;
		return vx < fx_add(hx, t) && fx_add(vx, t) > lx &&
			vy < fx_add(hy, t) && fx_add(vy, t) > ly;
	endfunction

	// Decides whether the two segments of a pair touch.
	function automatic logic segments_touch(pts_t p, logic [15:0] tol);
		fx_t t;
		fx_t ax;
		fx_t ay;
		fx_t bx;
		fx_t by;
		fx_t cx;
		fx_t cy;
		fx_t dx;
		fx_t dy;
		fx_t den;
		fx_t xi;
		fx_t yi;
		line_t l1;
		line_t l2;
		t = {32'h0, tol, 16'h0};
		ax = to_fx(p.seg_a_start_x);
		ay = to_fx(p.seg_a_start_y);
		bx = to_fx(p.seg_a_end_x);
		by = to_fx(p.seg_a_end_y);
		cx = to_fx(p.seg_b_start_x);
		cy = to_fx(p.seg_b_start_y);
		dx = to_fx(p.seg_b_end_x);
		dy = to_fx(p.seg_b_end_y);
		l1 = line_through(ax, ay, bx, by, t);
		l2 = line_through(cx, cy, dx, dy, t);
		if (within_tol(fx_sub(l1.a, l2.a), t) && within_tol(fx_sub(l1.b, l2.b), t)) begin
			if (!within_tol(fx_sub(l1.c, l2.c), t))
				return 1'b0;
			return in_span(ax, ay, cx, cy, dx, dy, t) || in_span(bx, by, cx, cy, dx, dy, t) ||
				in_span(cx, cy, ax, ay, bx, by, t) || in_span(dx, dy, ax, ay, bx, by, t);
		end
		den = fx_sub(fx_mul(l1.a, l2.b), fx_mul(l1.b, l2.a));
		if (den == 0)
			return 1'b0;
		xi = fx_div(fx_sub(fx_mul(l1.b, l2.c), fx_mul(l1.c, l2.b)), den);
		if (within_tol(l1.b, t))
			yi = fx_sub(fx_neg(fx_mul(l2.a, xi)), l2.c);
		else
			yi = fx_sub(fx_neg(fx_mul(l1.a, xi)), l1.c);
		return in_span(xi, yi, ax, ay, bx, by, t) && in_span(xi, yi, cx, cy, dx, dy, t);
	endfunction

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	// Coordinate helpers: whole units, and small values in Q16.16.
	function automatic logic [31:0] units(int k);
		return 32'(k * 65536);
	endfunction

	function automatic logic [31:0] near_coord();
		return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
	endfunction

	function automatic logic [31:0] edge_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return 32'h1;
			4: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic pts_t make_pair(int ax, int ay, int bx, int by,
			int cx, int cy, int dx, int dy);
		pts_t p;
		p.seg_a_start_x = units(ax);
		p.seg_a_start_y = units(ay);
		p.seg_a_end_x = units(bx);
		p.seg_a_end_y = units(by);
		p.seg_b_start_x = units(cx);
		p.seg_b_start_y = units(cy);
		p.seg_b_end_x = units(dx);
		p.seg_b_end_y = units(dy);
		return p;
	endfunction

	// A random pair, mostly shaped so that touching and near misses are common.
	function automatic pts_t random_pair();
		pts_t p;
		int k;
		int off;
		case ($urandom_range(0, 7))
			0: p = {$urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom};
			1: p = {near_coord(), near_coord(), near_coord(), near_coord(),
					near_coord(), near_coord(), near_coord(), near_coord()};
			2: begin
				p = {near_coord(), near_coord(), near_coord(), near_coord(),
					32'h0, 32'h0, near_coord(), near_coord()};
				p.seg_b_start_x = p.seg_a_end_x;
				p.seg_b_start_y = p.seg_a_end_y;
			end
			3: begin
				// Segments mostly on one shared line, overlapping or not.
				k = $urandom_range(0, 4) - 2;
				off = $urandom_range(0, 6) - 3;
				p.seg_a_start_x = near_coord();
				p.seg_a_end_x = near_coord();
				p.seg_b_start_x = near_coord();
				p.seg_b_end_x = near_coord();
				p.seg_a_start_y = 32'($signed(p.seg_a_start_x) * k) + units(off);
				p.seg_a_end_y = 32'($signed(p.seg_a_end_x) * k) + units(off);
				p.seg_b_start_y = 32'($signed(p.seg_b_start_x) * k) + units(off);
				p.seg_b_end_y = 32'($signed(p.seg_b_end_x) * k) + units(off);
				if ($urandom_range(0, 3) == 0) begin
					p.seg_a_end_x = p.seg_a_start_x;
					p.seg_b_start_x = p.seg_a_start_x;
					p.seg_b_end_x = p.seg_a_start_x + $urandom_range(0, 3);
				end
			end
			4: p = make_pair($urandom_range(0, 16) - 8, 0, $urandom_range(0, 16) - 8, 0,
					$urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
					$urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8);
			5: begin
				p = {near_coord(), near_coord(), 32'h0, near_coord(),
					near_coord(), near_coord(), near_coord(), near_coord()};
				p.seg_a_end_x = p.seg_a_start_x + 32'($urandom_range(0, 8)) - 32'd4;
			end
			6: p = {edge_coord(), edge_coord(), edge_coord(), edge_coord(),
					edge_coord(), edge_coord(), edge_coord(), edge_coord()};
			default: p = make_pair($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
					$urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
					$urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
					$urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4);
		endcase
		return p;
	endfunction

	// Hand-picked pairs: crossings, touching ends, shared lines, degenerate and extreme.
	task automatic queue_directed();
		pending_pairs.push_back(make_pair(-2, -2, 2, 2, -2, 2, 2, -2));
		pending_pairs.push_back(make_pair(0, 0, 4, 0, 4, 0, 4, 4));
		pending_pairs.push_back(make_pair(0, 0, 4, 0, 5, 1, 5, 4));
		pending_pairs.push_back(make_pair(0, 0, 4, 0, 2, 0, 6, 0));
		pending_pairs.push_back(make_pair(0, 0, 2, 0, 3, 0, 6, 0));
		pending_pairs.push_back(make_pair(0, 0, 4, 4, 0, 1, 4, 5));
		pending_pairs.push_back(make_pair(1, 0, 1, 5, 1, 2, 1, 8));
		pending_pairs.push_back(make_pair(1, 0, 1, 5, 2, 0, 2, 5));
		pending_pairs.push_back(make_pair(1, -3, 1, 3, -3, 0, 3, 0));
		pending_pairs.push_back(make_pair(2, 2, 2, 2, 2, 2, 2, 2));
		pending_pairs.push_back(make_pair(2, 2, 2, 2, 0, 0, 4, 4));
		pending_pairs.push_back(make_pair(0, 0, 3, 1, 0, 0, 3, 1));
		pending_pairs.push_back(make_pair(0, 0, 4, 2, 0, 3, 4, 1));
		pending_pairs.push_back({8{32'h7fff_ffff}});
		pending_pairs.push_back({8{32'h8000_0000}});
		pending_pairs.push_back({32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000});
		pending_pairs.push_back({32'h0, 32'h0, 32'h1, 32'h7fff_ffff,
			32'h8000_0000, 32'h1, 32'h7fff_ffff, 32'h0});
		pending_pairs.push_back({32'h0, 32'h0, 32'h1, 32'h1,
			32'h0, 32'h1, 32'h1, 32'h0});
		pending_pairs.push_back({32'h0, 32'h0, 32'h0, 32'h7fff_ffff,
			32'h0, 32'h0, 32'h1, 32'h8000_0000});
	endtask

	// Pair driver: presents pending pairs with random gaps and predicts each transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_in.valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (pairs_in.valid && pairs_in.ready) begin
				expected_touch.push_back(segments_touch(cur_pair, tol_now));
				pairs_sent++;
				if ($urandom_range(0, 63) == 0)
					burst_mode = !burst_mode;
				send_gap = burst_mode ? 0 : $urandom_range(0, 16);
			end
			if (!pairs_in.valid || pairs_in.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					pairs_in.valid <= 1'b0;
				end else if (pending_pairs.size() > 0) begin
					cur_pair = pending_pairs.pop_front();
					pairs_in.valid <= 1'b1;
					pairs_in.seg_a_start_x <= cur_pair.seg_a_start_x;
					pairs_in.seg_a_start_y <= cur_pair.seg_a_start_y;
					pairs_in.seg_a_end_x <= cur_pair.seg_a_end_x;
					pairs_in.seg_a_end_y <= cur_pair.seg_a_end_y;
					pairs_in.seg_b_start_x <= cur_pair.seg_b_start_x;
					pairs_in.seg_b_start_y <= cur_pair.seg_b_start_y;
					pairs_in.seg_b_end_x <= cur_pair.seg_b_end_x;
					pairs_in.seg_b_end_y <= cur_pair.seg_b_end_y;
				end else begin
					pairs_in.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: random stalls, one long hold-off on request, checks each transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_out.ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (result_out.valid && result_out.ready) begin
				results_seen++;
				if (expected_touch.size() == 0) begin
					report($sformatf("result %0d arrived with nothing expected", results_seen));
				end else if (result_out.touches !== expected_touch[0]) begin
					report($sformatf("result %0d touches=%b, expected %b", results_seen,
						result_out.touches, expected_touch[0]));
					void'(expected_touch.pop_front());
				end else begin
					touch_count += expected_touch.pop_front();
				end
				hold_left = burst_mode ? 0 : $urandom_range(0, 16);
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_out.ready <= 1'b0;
			end else begin
				result_out.ready <= 1'b1;
			end
		end
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic wait_idle();
		while (pending_pairs.size() > 0 || pairs_in.valid || expected_touch.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_tolerance(input logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tol_now = value;
	endtask

	// Phases over several tolerances; the sender waits for every result between them.
	initial begin
		logic [15:0] tol_plan[6];
		tol_plan = '{16'd1, 16'd0, 16'd65535, 16'd16, 16'd0, 16'd1};
		errors = 0;
		pairs_sent = 0;
		results_seen = 0;
		touch_count = 0;
		cycles = 0;
		burst_mode = 1'b0;
		long_hold_req = 1'b0;
		tol_now = TOL_RESET;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		pairs_in.valid = 1'b0;
		pairs_in.seg_a_start_x = '0;
		pairs_in.seg_a_start_y = '0;
		pairs_in.seg_a_end_x = '0;
		pairs_in.seg_a_end_y = '0;
		pairs_in.seg_b_start_x = '0;
		pairs_in.seg_b_start_y = '0;
		pairs_in.seg_b_end_x = '0;
		pairs_in.seg_b_end_y = '0;
		result_out.ready = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 4)
				tol_plan[ph] = 16'($urandom_range(1, 65534));
			if (ph > 0)
				set_tolerance(tol_plan[ph]);
			queue_directed();
			for (int i = 0; i < 190; i++)
				pending_pairs.push_back(random_pair());
			if (ph == 2) begin
				// Starve the output while the sender keeps going, so the pipeline backs up.
				burst_mode = 1'b1;
				long_hold_req = 1'b1;
			end
			wait_idle();
		end
		$display("%0d segment pairs checked over six tolerance settings, %0d of them touching.",
			results_seen, touch_count);
		$display("Mismatches: %0d.", errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
